FILE: src/wildcard_byte_pattern_search_defines.svh
// assertion macros used by the pattern search rtl
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_DEFINES_SVH

// condition that holds on every clock outside reset
`define WBPS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition that holds at the implication's edge
`define WBPS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition that holds in the cycle after the trigger
`define WBPS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/wbps_pkg.sv
// types, constants and pattern helpers of the pattern search block
`default_nettype none
package wbps_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int MASK_W = 16;
  localparam int LEN_W = 5;
  localparam int OFFSET_OUT_W = 32;
  localparam int IDX_W = 7;
  localparam int BYTES_PER_WORD = CFG_DATA_W / BYTE_W;
  localparam int PAT_BYTE_COUNT = 2 * BYTES_PER_WORD;

  localparam int PATTERN_LEN_DEFAULT = 16;
  localparam int OFFSET_BITS_DEFAULT = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_low;
    logic [CFG_DATA_W-1:0] pattern_high;
    logic [MASK_W-1:0]     wildcard_mask;
    logic [LEN_W-1:0]      pattern_length;
  } cfg_t;

  // pattern byte at position i, zero beyond the sixteen bytes of the two pattern words
  function automatic logic [BYTE_W-1:0] pattern_byte(input cfg_t cfg,
                                                     input logic [IDX_W-1:0] i);
    logic [BYTE_W-1:0] b;
    b = '0;
    if (i < IDX_W'(BYTES_PER_WORD)) begin
      b = cfg.pattern_low[{i[2:0], 3'b000} +: BYTE_W];
    end else if (i < IDX_W'(PAT_BYTE_COUNT)) begin
      b = cfg.pattern_high[{i[2:0], 3'b000} +: BYTE_W];
    end
    return b;
  endfunction

  // wildcard flag at position i, never set beyond the mask
  function automatic logic is_wild(input cfg_t cfg, input logic [IDX_W-1:0] i);
    logic w;
    w = 1'b0;
    if (i < IDX_W'(MASK_W)) begin
      w = cfg.wildcard_mask[i[3:0]];
    end
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: src/wildcard_byte_pattern_search.sv
// top level of the wildcard byte pattern search
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s       | in  | s_tvalid/s_tready  | s_tdata = data_byte, s_tlast = image_end
//  m       | out | m_tvalid/m_tready  | m_tdata = match_offset, m_tuser = found
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// one byte a cycle unless the output stalls; a byte's result word passes stages 1 and 2
// the rate is set by the window compare across the cell row, done combinationally
// stage 1 is the cell row plus the byte's offset, stage 2 compares into the output register
// reset clears configuration, offset counter, reported flag and valids; window bytes stay
// a stalled output holds; one more byte is still taken into an empty stage 1 behind it
`default_nettype none
`include "wildcard_byte_pattern_search_defines.svh"
module wildcard_byte_pattern_search #(
  parameter int PATTERN_LEN = wbps_pkg::PATTERN_LEN_DEFAULT,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire                                clk,
  input  wire                                rst,
  // input words
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [7:0]                         s_tdata,   // [7:0] data_byte
  input  wire                                s_tlast,   // image_end
  // result words
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [31:0]                        m_tdata,   // [31:0] match_offset
  output logic [0:0]                         m_tuser,   // [0] found
  // configuration writes
  input  wire                                cfg_we,
  input  wire  [wbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [wbps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LEN_CMP_W = wbps_pkg::IDX_W;

  wbps_pkg::cfg_t cfg;

  // handshakes
  logic s_accept;
  logic out_free;
  logic s2_take;

  // stage 1: byte offset and image end of the newest byte in the window
  logic                   s1_valid;
  logic                   s1_last;
  logic [OFFSET_BITS-1:0] s1_pos;
  logic [OFFSET_BITS-1:0] bytes_seen;

  // stage 2 state
  logic reported;

  // cell row
  logic [wbps_pkg::BYTE_W-1:0] win [PATTERN_LEN];
  logic [PATTERN_LEN-1:0]      hits;

  // compare results
  logic [OFFSET_BITS:0]    len_ext;
  logic [OFFSET_BITS:0]    pos_plus;
  logic [OFFSET_BITS:0]    start_full;
  logic [OFFSET_BITS+wbps_pkg::OFFSET_OUT_W:0] start_wide;
  logic                    len_ok;
  logic                    window_hit;
  logic                    emit;

  wbps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // row of cells, the newest byte enters cell 0
  for (genvar k = 0; k < PATTERN_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      wbps_cell #(.CELL_INDEX(k)) u_cell (
        .clk   (clk),
        .shift (s_accept),
        .din   (s_tdata),
        .cfg   (cfg),
        .dout  (win[k]),
        .hit   (hits[k])
      );
    end else begin : g_body
      wbps_cell #(.CELL_INDEX(k)) u_cell (
        .clk   (clk),
        .shift (s_accept),
        .din   (win[k-1]),
        .cfg   (cfg),
        .dout  (win[k]),
        .hit   (hits[k])
      );
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign s2_take  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign s_accept = s_tvalid && s_tready;

  // stage 1 bookkeeping, offset saturates at all ones
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      bytes_seen <= '0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s2_take) begin
        s1_valid <= 1'b0;
      end
      if (s_accept) begin
        if (s_tlast) begin
          bytes_seen <= '0;
        end else if (bytes_seen != '1) begin
          bytes_seen <= bytes_seen + OFFSET_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_pos  <= bytes_seen;
      s1_last <= s_tlast;
    end
  end

  // window compare: all cells hit, length in range, enough bytes seen, offset not saturated
  always_comb begin
    len_ext    = (OFFSET_BITS+1)'(cfg.pattern_length);
    pos_plus   = {1'b0, s1_pos} + (OFFSET_BITS+1)'(1);
    start_full = pos_plus - len_ext;
    start_wide = {{wbps_pkg::OFFSET_OUT_W{1'b0}}, start_full};
    len_ok     = (cfg.pattern_length != '0) &&
                 (LEN_CMP_W'(cfg.pattern_length) <= LEN_CMP_W'(PATTERN_LEN));
    window_hit = len_ok && (&hits) && (s1_pos != '1) && (pos_plus >= len_ext);
    emit       = !reported && (window_hit || s1_last);
  end

  // stage 2: reported flag and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      reported <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s2_take) begin
        if (s1_last) begin
          reported <= 1'b0;
        end else if (!reported && window_hit) begin
          reported <= 1'b1;
        end
      end
      if (out_free) begin
        m_tvalid <= s2_take && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && emit) begin
      m_tuser[0] <= window_hit;
      m_tdata    <= window_hit ? start_wide[wbps_pkg::OFFSET_OUT_W-1:0] : '0;
    end
  end

  // a byte in stage 1 that cannot move keeps its offset
  `WBPS_ASSERT_NEXT(a_s1_hold, s1_valid && !s2_take, s1_valid && $stable(s1_pos), "stage 1 word lost")
  // a first match mid image marks the image as reported
  `WBPS_ASSERT_NEXT(a_reported_set, s2_take && !reported && window_hit && !s1_last, reported, "match not recorded")
  // a no-match result carries a zero offset
  `WBPS_ASSERT_IMPL(a_nomatch_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "nonzero offset without match")
  // the offset counter restarts after an image end
  `WBPS_ASSERT_NEXT(a_count_clear, s_accept && s_tlast, bytes_seen == '0, "offset not cleared at image end")
  // an empty output register never blocks input
  `WBPS_ASSERT(a_ready_free, m_tvalid || s_tready, "input blocked with empty output")

endmodule
`default_nettype wire

FILE: src/wbps_cfg.sv
// configuration registers of the pattern search block
`default_nettype none
module wbps_cfg (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire  [wbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [wbps_pkg::CFG_DATA_W-1:0]      cfg_data,
  output wbps_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wbps_pkg::REG_PATTERN_LOW: begin
          cfg.pattern_low <= cfg_data;
        end
        wbps_pkg::REG_PATTERN_HIGH: begin
          cfg.pattern_high <= cfg_data;
        end
        wbps_pkg::REG_WILDCARD_MASK: begin
          cfg.wildcard_mask <= cfg_data[wbps_pkg::MASK_W-1:0];
        end
        wbps_pkg::REG_PATTERN_LENGTH: begin
          cfg.pattern_length <= cfg_data[wbps_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/wbps_cell.sv
// one window cell: holds a byte, hands it on, compares it to its pattern byte
`default_nettype none
module wbps_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire                            clk,
  input  wire                            shift,
  input  wire  [wbps_pkg::BYTE_W-1:0]    din,
  input  wire  wbps_pkg::cfg_t           cfg,
  output logic [wbps_pkg::BYTE_W-1:0]    dout,
  output logic                           hit
);

  localparam logic [wbps_pkg::IDX_W-1:0] K = wbps_pkg::IDX_W'(CELL_INDEX);

  logic [wbps_pkg::IDX_W-1:0] len_ext;
  logic [wbps_pkg::IDX_W-1:0] pat_idx;
  logic                       care;

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

  // cell k lines up with pattern byte len-1-k, outside the pattern it always hits
  always_comb begin
    len_ext = wbps_pkg::IDX_W'(cfg.pattern_length);
    care    = K < len_ext;
    pat_idx = len_ext - wbps_pkg::IDX_W'(1) - K;
    hit     = !care || wbps_pkg::is_wild(cfg, pat_idx) ||
              (dout == wbps_pkg::pattern_byte(cfg, pat_idx));
  end

endmodule
`default_nettype wire
